FILE: hw/rtl/esl_pkg.sv
// Shared types and constants for the entity slot table.
// Used by esl_cell, esl_ctrl and entity_slot_table; no dependencies.
package esl_pkg;

    localparam int DEFAULT_CAPACITY = 64;

    localparam int KIND_W   = 3;
    localparam int ENT_W    = 16;
    localparam int POS_W    = 7;
    localparam int SLOT_W   = 6;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_SET       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE_AT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NEXT      = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ENT_W-1:0]  entity;
        logic              allow_duplicate;
        logic [POS_W-1:0]  position;
    } esl_in_t;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic [ENT_W-1:0]    entity_out;
        logic [POS_W-1:0]    next_position;
        logic [LEN_W-1:0]    length;
        logic [STATUS_W-1:0] status;
    } esl_out_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             shift;
        logic             settle;
        logic             claim;
        logic [ENT_W-1:0] claim_ent;
    } esl_cell_ctl_t;

endpackage

FILE: hw/rtl/entity_slot_table.sv
// Top level of the entity slot table: ring of slot cells plus head sequencer.
// Depends on esl_pkg, esl_cell and esl_ctrl.
//
// The table holds CAPACITY slots in a ring of cells that rotates one slot past
// the sequencer at the head each cycle while it scans; every operation (set,
// lookup, remove entity, remove at slot, clear, next) makes exactly one full
// turn, rewriting each slot as it passes, so the ring is back in place when
// the turn ends. A set claims the lowest free slot with a tentative mark during
// the turn and commits it in the finish cycle once it is known whether the
// entity is already present. An item passes from its accepted input beat
// through the rotation, then the finish state that loads the result register,
// then the idle state, where the next input beat is taken. The result beat is
// offered and held in an output register; a new input beat is taken while it
// waits, and the finish of that next item holds until the earlier result beat
// is taken. The user must write the empty marker through cfg_we/cfg_data only
// while the block is idle; the block itself does not enforce this. Rewriting
// the marker does not rewrite any slot. Reset empties every slot (marker 0) and
// sets the length to zero at once; no clearing pass is needed.
module entity_slot_table #(
    parameter int CAPACITY = esl_pkg::DEFAULT_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  esl_pkg::esl_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output esl_pkg::esl_out_t out_data
);
    import esl_pkg::*;

    // ring wiring: cell k takes from cell k+1, the last cell from the head
    logic [ENT_W-1:0] cell_data [CAPACITY];
    logic             cell_mark [CAPACITY];
    logic [ENT_W-1:0] tail_data;
    logic             tail_mark;
    esl_cell_ctl_t    cell_ctl;

    esl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .head_data (cell_data[0]),
        .tail_data (tail_data),
        .tail_mark (tail_mark),
        .cell_ctl  (cell_ctl)
    );

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        if (k == CAPACITY - 1)
        begin : g_last
            // close the ring through the head's rewritten slot
            esl_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (cell_ctl),
                .data_in (tail_data),
                .mark_in (tail_mark),
                .data_q  (cell_data[k]),
                .mark_q  (cell_mark[k])
            );
        end
        else
        begin : g_mid
            esl_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (cell_ctl),
                .data_in (cell_data[k+1]),
                .mark_in (cell_mark[k+1]),
                .data_q  (cell_data[k]),
                .mark_q  (cell_mark[k])
            );
        end
    end

endmodule

FILE: hw/rtl/esl_cell.sv
// One slot of the rotating slot ring: entity id plus a tentative-claim mark.
// Depends on esl_pkg.
module esl_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  esl_pkg::esl_cell_ctl_t ctl,
    input  logic [15:0]           data_in,
    input  logic                  mark_in,
    output logic [15:0]           data_q,
    output logic                  mark_q
);
    import esl_pkg::*;

    logic [ENT_W-1:0] data_reg;
    logic             mark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
            mark_reg <= 1'b0;
        end
        else if (ctl.settle)
        begin
            // commit a pending claim, drop the mark either way
            if (ctl.claim && mark_reg)
            begin
                data_reg <= ctl.claim_ent;
            end
            mark_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            data_reg <= data_in;
            mark_reg <= mark_in;
        end
    end

    assign data_q = data_reg;
    assign mark_q = mark_reg;

endmodule

FILE: hw/rtl/esl_ctrl.sv
// Sequencer at the head of the slot ring: scans one slot per cycle,
// rewrites it, gathers the result and holds the high-water length.
// Depends on esl_pkg.
module esl_ctrl #(
    parameter int CAPACITY = esl_pkg::DEFAULT_CAPACITY
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  esl_pkg::esl_in_t       in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output esl_pkg::esl_out_t      out_data,
    input  logic [15:0]            head_data,
    output logic [15:0]            tail_data,
    output logic                   tail_mark,
    output esl_pkg::esl_cell_ctl_t cell_ctl
);
    import esl_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int HW_W  = $clog2(CAPACITY + 1);
    localparam int CW    = ((HW_W > POS_W) ? HW_W : POS_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg;
    esl_in_t           op_reg;
    logic [ENT_W-1:0]  marker_reg;
    logic [HW_W-1:0]   hw_reg, hw_next;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [ENT_W-1:0]  hit_val_reg;
    logic              free_ok_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              tail_reg;
    logic [HW_W-1:0]   top_reg;
    logic              out_valid_reg;
    esl_out_t          out_reg, out_next;

    logic              accept, load;
    logic              refused, is_ent, is_free, below, at_tail, at_pos, match, clear_it;
    logic              kind_set, kind_lookup, kind_remove, kind_remove_at, kind_clear, kind_next;
    logic              claim;
    logic [CW-1:0]     i_ext, pos_ext, hw_ext;
    logic [HW_W-1:0]   i_plus;
    logic [ENT_W-1:0]  w;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    assign kind_set       = (op_reg.kind == KIND_SET);
    assign kind_lookup    = (op_reg.kind == KIND_LOOKUP);
    assign kind_remove    = (op_reg.kind == KIND_REMOVE);
    assign kind_remove_at = (op_reg.kind == KIND_REMOVE_AT);
    assign kind_clear     = (op_reg.kind == KIND_CLEAR);
    assign kind_next      = (op_reg.kind == KIND_NEXT);

    assign refused = (op_reg.entity == marker_reg);
    assign is_ent  = (head_data == op_reg.entity);
    assign is_free = (head_data == marker_reg);
    assign i_ext   = CW'(idx_reg);
    assign pos_ext = CW'(op_reg.position);
    assign hw_ext  = CW'(hw_reg);
    assign i_plus  = HW_W'(idx_reg) + HW_W'(1);
    assign below   = (HW_W'(idx_reg) < hw_reg);
    assign at_tail = (i_plus == hw_reg);
    assign at_pos  = (i_ext == pos_ext);

    // per-slot decisions at the head of the ring
    always_comb
    begin
        match = 1'b0;
        if ((kind_set || kind_lookup || kind_remove) && !refused)
        begin
            match = below && is_ent;
        end
        else if (kind_next)
        begin
            match = below && !is_free && (i_ext >= pos_ext);
        end
        else if (kind_remove_at)
        begin
            match = at_pos && !is_free;
        end
        // freeing the top slot re-opens the scan above the old length
        clear_it = (kind_remove && !refused && is_ent && (below || tail_reg))
                || (kind_remove_at && at_pos)
                || kind_clear;
        w = clear_it ? marker_reg : head_data;
    end

    assign tail_data = w;
    assign tail_mark = (state_reg == ST_SCAN) && kind_set && !refused && is_free
                    && !free_ok_reg;

    assign claim = kind_set && !refused && free_ok_reg
                && !(!op_reg.allow_duplicate && hit_reg);

    assign cell_ctl.shift     = (state_reg == ST_SCAN);
    assign cell_ctl.settle    = load;
    assign cell_ctl.claim     = claim;
    assign cell_ctl.claim_ent = op_reg.entity;

    // result and new length
    always_comb
    begin
        out_next        = '0;
        out_next.status = STATUS_NOT_FOUND;
        hw_next         = hw_reg;
        case (op_reg.kind)
            KIND_SET:
            begin
                if (refused)
                begin
                    out_next.status = STATUS_REFUSED;
                end
                else if (!op_reg.allow_duplicate && hit_reg)
                begin
                    out_next.found      = 1'b1;
                    out_next.slot       = SLOT_W'(hit_idx_reg);
                    out_next.entity_out = op_reg.entity;
                    out_next.status     = STATUS_OK;
                end
                else if (free_ok_reg)
                begin
                    out_next.found      = 1'b1;
                    out_next.slot       = SLOT_W'(free_idx_reg);
                    out_next.entity_out = op_reg.entity;
                    out_next.status     = STATUS_OK;
                    if ((HW_W'(free_idx_reg) + HW_W'(1)) > hw_reg)
                    begin
                        hw_next = HW_W'(free_idx_reg) + HW_W'(1);
                    end
                end
                else
                begin
                    out_next.status = STATUS_FULL;
                end
            end
            KIND_LOOKUP, KIND_REMOVE:
            begin
                if (refused)
                begin
                    out_next.status = STATUS_REFUSED;
                end
                else if (hit_reg)
                begin
                    out_next.found      = 1'b1;
                    out_next.slot       = SLOT_W'(hit_idx_reg);
                    out_next.entity_out = op_reg.entity;
                    out_next.status     = STATUS_OK;
                end
                if (kind_remove && !refused && tail_reg)
                begin
                    hw_next = top_reg;
                end
            end
            KIND_REMOVE_AT:
            begin
                if (hit_reg)
                begin
                    out_next.found      = 1'b1;
                    out_next.slot       = SLOT_W'(hit_idx_reg);
                    out_next.entity_out = hit_val_reg;
                    out_next.status     = STATUS_OK;
                end
                if (hw_ext == pos_ext + CW'(1))
                begin
                    hw_next = top_reg;
                end
            end
            KIND_CLEAR:
            begin
                out_next.status = STATUS_OK;
                hw_next         = '0;
            end
            KIND_NEXT:
            begin
                if (hit_reg)
                begin
                    out_next.found         = 1'b1;
                    out_next.slot          = SLOT_W'(hit_idx_reg);
                    out_next.entity_out    = hit_val_reg;
                    out_next.status        = STATUS_OK;
                    out_next.next_position = POS_W'(CW'(hit_idx_reg) + CW'(1));
                end
                else if (pos_ext < hw_ext)
                begin
                    out_next.next_position = POS_W'(hw_reg);
                end
                else
                begin
                    out_next.next_position = op_reg.position;
                end
            end
            default:
            begin
                out_next.status = STATUS_NOT_FOUND;
            end
        endcase
        out_next.length = LEN_W'(hw_next);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            marker_reg    <= '0;
            hw_reg        <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            free_ok_reg   <= 1'b0;
            tail_reg      <= 1'b0;
            top_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                marker_reg <= cfg_data;
            end
            if (accept)
            begin
                idx_reg     <= '0;
                hit_reg     <= 1'b0;
                free_ok_reg <= 1'b0;
                tail_reg    <= 1'b0;
                top_reg     <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (match && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (tail_mark)
                begin
                    free_ok_reg <= 1'b1;
                end
                if (kind_remove && !refused && is_ent && at_tail)
                begin
                    tail_reg <= 1'b1;
                end
                if (w != marker_reg)
                begin
                    top_reg <= i_plus;
                end
            end
            if (load)
            begin
                hw_reg        <= hw_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= in_data;
        end
        if ((state_reg == ST_SCAN) && match && !hit_reg)
        begin
            hit_idx_reg <= idx_reg;
            hit_val_reg <= head_data;
        end
        if (tail_mark)
        begin
            free_idx_reg <= idx_reg;
        end
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= HW_W'(CAPACITY))
        else $error("high-water length beyond capacity");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_settle_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctl.settle |-> (state_reg == ST_FINISH) && !cell_ctl.shift)
        else $error("ring settled outside finish");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.found) |-> (out_reg.slot == '0)
            && (out_reg.entity_out == '0))
        else $error("miss reports a slot or entity");

    a_tail_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && tail_reg) |-> hit_reg)
        else $error("top slot freed without a recorded match");

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for entity_slot_table (set, lookup, removals, clear, next).
// Depends on esl_pkg and the entity_slot_table RTL; every result is predicted by a shadow
// copy of the slot table kept here and checked field by field.
`timescale 1ns / 1ps

module tb_top;
    import esl_pkg::*;

    localparam int CAP         = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_TAIL = CAP + 8;

    // kinds outside the defined operation set; the block must answer them as no-ops
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    typedef enum int {FILL_HEAVY, CHURN, WALK} mix_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    logic     [15:0] cfg_data = '0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    esl_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    esl_out_t out_data;

    entity_slot_table #(.CAPACITY(CAP)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow slot table: ids per slot, high-water length, current marker.
    // ------------------------------------------------------------------
    logic [15:0] shadow_ids [CAP];
    int          shadow_len = 0;
    logic [15:0] shadow_marker = '0;

    esl_in_t  ops_to_send [$];   // operations not yet offered to the block
    esl_out_t replies_due [$];   // predicted results, oldest first

    int ops_accepted = 0;
    int replies_checked = 0;
    int error_count = 0;
    int input_stalls = 0;
    int marker_writes = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    logic [15:0] id_pool [16];
    int          walk_at = 0;

    initial
    begin
        for (int i = 0; i < CAP; i++)
            shadow_ids[i] = '0;
    end

    // Free one slot; when it was the top occupied one, pull the length down
    // to one past the highest slot still in use.
    function automatic void release_slot(int idx);
        shadow_ids[idx] = shadow_marker;
        if (shadow_len == idx + 1)
        begin
            shadow_len = 0;
            for (int i = 0; i < CAP; i++)
                if (shadow_ids[i] != shadow_marker)
                    shadow_len = i + 1;
        end
    endfunction

    // Lowest slot below the length holding the id, or -1.
    function automatic int find_live(logic [15:0] id);
        for (int i = 0; i < shadow_len && i < CAP; i++)
            if (shadow_ids[i] == id)
                return i;
        return -1;
    endfunction

    // Apply one operation to the shadow table and return the result it yields.
    function automatic esl_out_t table_apply(esl_in_t op);
        esl_out_t r;
        int       loc;
        int       np;
        r = '0;
        r.status = STATUS_NOT_FOUND;
        case (op.kind)
            KIND_SET:
            begin
                if (op.entity == shadow_marker)
                    r.status = STATUS_REFUSED;
                else
                begin
                    loc = op.allow_duplicate ? -1 : find_live(op.entity);
                    if (loc < 0)
                    begin
                        // claim the lowest free slot, or report full
                        r.status = STATUS_FULL;
                        for (int i = 0; i < CAP && loc < 0; i++)
                            if (shadow_ids[i] == shadow_marker)
                                loc = i;
                        if (loc >= 0)
                        begin
                            shadow_ids[loc] = op.entity;
                            if (loc + 1 > shadow_len)
                                shadow_len = loc + 1;
                        end
                    end
                    if (loc >= 0)
                    begin
                        r.found = 1'b1;
                        r.slot = SLOT_W'(loc);
                        r.entity_out = op.entity;
                        r.status = STATUS_OK;
                    end
                end
            end
            KIND_LOOKUP:
            begin
                if (op.entity == shadow_marker)
                    r.status = STATUS_REFUSED;
                else
                begin
                    loc = find_live(op.entity);
                    if (loc >= 0)
                    begin
                        r.found = 1'b1;
                        r.slot = SLOT_W'(loc);
                        r.entity_out = op.entity;
                        r.status = STATUS_OK;
                    end
                end
            end
            KIND_REMOVE:
            begin
                if (op.entity == shadow_marker)
                    r.status = STATUS_REFUSED;
                else
                    // the bound shrinks as the top slots are freed
                    for (int i = 0; i < shadow_len && i < CAP; i++)
                        if (shadow_ids[i] == op.entity)
                        begin
                            if (!r.found)
                            begin
                                r.found = 1'b1;
                                r.slot = SLOT_W'(i);
                                r.entity_out = op.entity;
                                r.status = STATUS_OK;
                            end
                            release_slot(i);
                        end
            end
            KIND_REMOVE_AT:
            begin
                if (op.position < CAP)
                begin
                    if (shadow_ids[op.position] != shadow_marker)
                    begin
                        r.found = 1'b1;
                        r.slot = SLOT_W'(op.position);
                        r.entity_out = shadow_ids[op.position];
                        r.status = STATUS_OK;
                    end
                    release_slot(int'(op.position));
                end
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < CAP; i++)
                    shadow_ids[i] = shadow_marker;
                shadow_len = 0;
                r.status = STATUS_OK;
            end
            KIND_NEXT:
            begin
                np = op.position;
                while (!r.found && np < shadow_len && np < CAP)
                begin
                    if (shadow_ids[np] != shadow_marker)
                    begin
                        r.found = 1'b1;
                        r.slot = SLOT_W'(np);
                        r.entity_out = shadow_ids[np];
                        r.status = STATUS_OK;
                    end
                    np++;
                end
                if (!r.found && np < shadow_len)
                    np = shadow_len;
                r.next_position = POS_W'(np);
            end
            default: ;
        endcase
        r.length = LEN_W'(shadow_len);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly zero, often a few cycles, now and then a long stretch.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    function automatic esl_in_t make_op(logic [KIND_W-1:0] kind, logic [ENT_W-1:0] id,
                                        logic dup, int pos);
        esl_in_t op;
        op.kind = kind;
        op.entity = id;
        op.allow_duplicate = dup;
        op.position = POS_W'(pos);
        return op;
    endfunction

    // Draw ids from a small pool so that lookups and removals hit live slots.
    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 88)
            return id_pool[$urandom_range(0, 15)];
        if (r < 95)
            return 16'($urandom_range(0, 65535));
        return shadow_marker;
    endfunction

    function automatic esl_in_t random_op(mix_t mix);
        esl_in_t op;
        int      r;
        op.entity = pick_id();
        op.allow_duplicate = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0)
            op.position = POS_W'(CAP);
        else
            op.position = POS_W'($urandom_range(0, CAP - 1));
        op.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_7 : KIND_SPARE_6;
        r = $urandom_range(0, 99);
        case (mix)
            FILL_HEAVY:
            begin
                if (r < 85)
                begin
                    op.kind = KIND_SET;
                    op.allow_duplicate = ($urandom_range(0, 9) < 7);
                end
                else if (r < 92) op.kind = KIND_LOOKUP;
                else if (r < 96) op.kind = KIND_NEXT;
                else if (r < 99) op.kind = KIND_REMOVE_AT;
            end
            CHURN:
            begin
                if (r < 40) op.kind = KIND_SET;
                else if (r < 58) op.kind = KIND_LOOKUP;
                else if (r < 72) op.kind = KIND_REMOVE;
                else if (r < 84) op.kind = KIND_REMOVE_AT;
                else if (r < 94) op.kind = KIND_NEXT;
                else if (r < 96) op.kind = KIND_CLEAR;
            end
            default:
            begin
                // iterate: successive next requests walking up the table
                if (r < 45)
                begin
                    op.kind = KIND_NEXT;
                    op.position = POS_W'(walk_at);
                    walk_at += $urandom_range(1, 3);
                    if (walk_at > CAP)
                        walk_at = 0;
                end
                else if (r < 70) op.kind = KIND_SET;
                else if (r < 78) op.kind = KIND_REMOVE;
                else if (r < 88) op.kind = KIND_REMOVE_AT;
                else if (r < 96) op.kind = KIND_LOOKUP;
                else if (r < 97) op.kind = KIND_CLEAR;
            end
        endcase
        return op;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued operations, hold each beat until it is taken.
    // ------------------------------------------------------------------
    logic send_free;
    logic send_calm = 1'b0;
    int   send_wait = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            send_free = !in_valid;
            if (in_valid && in_ready)
            begin
                // predict at the accepting edge, in acceptance order
                replies_due.push_back(table_apply(in_data));
                ops_accepted <= ops_accepted + 1;
                send_free = 1'b1;
                send_wait = send_calm ? 0 : idle_len();
                if ($urandom_range(0, 39) == 0)
                    send_calm = !send_calm;
            end
            else if (in_valid)
                input_stalls++;
            if (send_free)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (ops_to_send.size() != 0)
                begin
                    in_data <= ops_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off: once mid-run, twice in all, drop ready for a long
    // stretch while the driver keeps offering, so the block backs up.
    // ------------------------------------------------------------------
    int hold_left = 0;
    int holds_done = 0;

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (holds_done < 2 && ops_accepted >= (holds_done == 0 ? 300 : 800))
        begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every result beat against the oldest prediction and
    // drive ready with random stalls.
    // ------------------------------------------------------------------
    logic recv_calm = 1'b0;
    int   recv_wait = 0;

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= 40)
                $display("%0t: result %0d field %s expected %0d actual %0d",
                         $time, replies_checked, name, want, got);
        end
    endtask

    task automatic check_reply(esl_out_t got);
        esl_out_t want;
        status_seen[got.status]++;
        if (replies_due.size() == 0)
        begin
            error_count++;
            if (error_count <= 40)
                $display("%0t: result beat with no operation outstanding, expected none actual %h",
                         $time, got);
        end
        else
        begin
            want = replies_due.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("slot", want.slot, got.slot);
            compare_field("entity_out", want.entity_out, got.entity_out);
            compare_field("next_position", want.next_position, got.next_position);
            compare_field("length", want.length, got.length);
            compare_field("status", want.status, got.status);
        end
        replies_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_reply(out_data);
            if (hold_left > 0)
                out_ready <= 1'b0;
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else if (!recv_calm && $urandom_range(0, 11) == 0)
            begin
                recv_wait = idle_len();
                out_ready <= (recv_wait == 0);
            end
            else
                out_ready <= 1'b1;
            if ($urandom_range(0, 299) == 0)
                recv_calm = !recv_calm;
        end
    end

    // Watchdog
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, replies_due.size());
            $display("entity_slot_table verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    // Wait until every queued beat was taken and every result came back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (ops_to_send.size() != 0 || in_valid || replies_due.size() != 0);
    endtask

    // Refill the id pool; keep the previous marker in it so slots still
    // holding that old value get looked up and removed.
    task automatic refresh_pool(logic [15:0] old_marker);
        id_pool[0] = old_marker;
        for (int i = 1; i < 16; i++)
            id_pool[i] = 16'($urandom_range(0, 65535));
    endtask

    // Rewrite the empty marker between phases, with the block idle.
    task automatic retune_marker(logic [15:0] value);
        logic [15:0] prev;
        prev = shadow_marker;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_marker = value;
        marker_writes++;
        refresh_pool(prev);
        @(negedge clk);
    endtask

    task automatic queue_phase(mix_t mix, int count);
        for (int n = 0; n < count; n++)
            ops_to_send.push_back(random_op(mix));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        refresh_pool(16'h0000);

        // Directed opening, marker at its reset value 0.
        ops_to_send.push_back(make_op(KIND_LOOKUP, 16'h0005, 1'b0, 0));      // empty table
        ops_to_send.push_back(make_op(KIND_SET, 16'h0000, 1'b1, 0));         // marker refused
        ops_to_send.push_back(make_op(KIND_LOOKUP, 16'h0000, 1'b0, 0));
        ops_to_send.push_back(make_op(KIND_REMOVE, 16'h0000, 1'b1, 0));
        ops_to_send.push_back(make_op(KIND_SET, 16'hFFFF, 1'b0, CAP));       // claim slot 0
        ops_to_send.push_back(make_op(KIND_SET, 16'hFFFF, 1'b0, 0));         // already present
        ops_to_send.push_back(make_op(KIND_SET, 16'hFFFF, 1'b1, 0));         // duplicate
        ops_to_send.push_back(make_op(KIND_SET, 16'h0001, 1'b0, 0));
        ops_to_send.push_back(make_op(KIND_LOOKUP, 16'hFFFF, 1'b1, 0));
        ops_to_send.push_back(make_op(KIND_NEXT, 16'h0000, 1'b0, 0));
        ops_to_send.push_back(make_op(KIND_NEXT, 16'hFFFF, 1'b0, CAP));      // past the length
        ops_to_send.push_back(make_op(KIND_REMOVE, 16'h1234, 1'b0, 0));      // no match
        ops_to_send.push_back(make_op(KIND_REMOVE, 16'hFFFF, 1'b0, 0));      // both copies
        ops_to_send.push_back(make_op(KIND_NEXT, 16'h0000, 1'b1, 0));        // skip free slots
        ops_to_send.push_back(make_op(KIND_REMOVE_AT, 16'h0000, 1'b0, 2));   // length drops to 0
        ops_to_send.push_back(make_op(KIND_REMOVE_AT, 16'h0000, 1'b0, 2));   // already free
        ops_to_send.push_back(make_op(KIND_REMOVE_AT, 16'hFFFF, 1'b1, CAP)); // out of range
        ops_to_send.push_back(make_op(KIND_NEXT, 16'h0000, 1'b0, 0));        // nothing occupied
        ops_to_send.push_back(make_op(KIND_SPARE_6, 16'h8000, 1'b1, 1));
        ops_to_send.push_back(make_op(KIND_SPARE_7, 16'h7FFF, 1'b0, 63));
        ops_to_send.push_back(make_op(KIND_SET, 16'h8000, 1'b0, 0));
        ops_to_send.push_back(make_op(KIND_SET, 16'h7FFF, 1'b1, 0));
        ops_to_send.push_back(make_op(KIND_REMOVE_AT, 16'h0000, 1'b0, 0));   // length holds at 2
        ops_to_send.push_back(make_op(KIND_NEXT, 16'h0000, 1'b0, 0));
        ops_to_send.push_back(make_op(KIND_CLEAR, 16'h5555, 1'b1, 42));

        // Random phases; the first is weighted toward sets to fill the table.
        queue_phase(FILL_HEAVY, 90);
        retune_marker(16'hFFFF);
        queue_phase(CHURN, 250);
        retune_marker(16'($urandom_range(1, 65534)));
        queue_phase(WALK, 200);
        retune_marker(16'h0000);
        queue_phase(CHURN, 300);
        retune_marker(16'($urandom_range(1, 65534)));
        queue_phase(FILL_HEAVY, 60);
        queue_phase(CHURN, 225);

        // Drain, then give any stray beat time to show up.
        wait_drained();
        repeat (SETTLE_TAIL) @(posedge clk);
        if (replies_due.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d predicted results never arrived", $time, replies_due.size());
        end

        $display("Ran %0d operations under %0d marker rewrites; %0d result beats checked.",
                 ops_accepted, marker_writes, replies_checked);
        $display("Status mix ok/not found/refused/full %0d/%0d/%0d/%0d; input stalled %0d cycles.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], input_stalls);
        if (error_count == 0)
            $display("entity_slot_table verification clean");
        else
            $display("entity_slot_table verification failed");
        $finish;
    end

endmodule
